[rtl/assert_macros.svh]
// Assertion macros shared by the text line normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define TLNZ_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Same-cycle implication checked at every rising edge outside of reset.
`define TLNZ_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/tlnz_pkg.sv]
// Shared constants and types of the text line normalizer.
`default_nettype none

package tlnz_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_EOL   = 2'd1;
  localparam logic [1:0] OP_BATCH = 2'd2;

  // Result kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 2'd2;

  // Field and counter widths.
  localparam int unsigned LCL_W = 16;
  localparam int unsigned LBL_W = 16;
  localparam int unsigned TBL_W = 20;
  localparam int unsigned POS_W = 17;
  localparam int unsigned CFG_DATA_W = 20;

  // Register reset values.
  localparam logic [LCL_W-1:0] LCL_RESET = 16'd64;
  localparam logic [LBL_W-1:0] LBL_RESET = 16'd256;
  localparam logic [TBL_W-1:0] TBL_RESET = 20'd4096;

  // Character constants.
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DEL_CHAR   = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

  // Trailing result of a queue entry: a space byte or an end of line marker.
  typedef struct packed {
    logic valid;
    logic kind;
    logic malformed;
  } tlnz_tail_t;

endpackage

`default_nettype wire

[rtl/tlnz_front.sv]
// Front end: accepts input items, tracks line state and builds result requests.
`default_nettype none

module tlnz_front #(
  parameter int unsigned GROUP_MAX = 4,
  localparam int unsigned CNT_W = $clog2(GROUP_MAX + 1),
  localparam int unsigned IDX_W = $clog2(GROUP_MAX)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input item channel.
  input  wire logic                                  in_valid,
  input  wire logic [1:0]                            in_op,
  input  wire logic [7:0]                            in_byte,
  output logic                                       in_ready,
  // Configuration write channel.
  input  wire logic                                  cfg_valid,
  input  wire logic [tlnz_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tlnz_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                       cfg_ready,
  // Request toward the queue.
  output logic                                       push_valid,
  input  wire logic                                  push_ready,
  output logic [GROUP_MAX-1:0][7:0]                  push_bytes,
  output logic [CNT_W-1:0]                           push_n,
  output tlnz_pkg::tlnz_tail_t                       push_tail
);

  // Configuration registers.
  logic [tlnz_pkg::LCL_W-1:0] lcl_r;
  logic [tlnz_pkg::LBL_W-1:0] lbl_r;
  logic [tlnz_pkg::TBL_W-1:0] tbl_r;

  // Line and batch state.
  logic [GROUP_MAX-1:0][7:0]  grp_r, grp_nxt;
  logic [CNT_W-1:0]           hc_r, hc_nxt;
  logic [tlnz_pkg::POS_W-1:0] hs_r, hs_nxt;
  logic [tlnz_pkg::POS_W-1:0] lp_r, lp_nxt;
  logic                       sp_r, sp_nxt;
  logic [tlnz_pkg::LBL_W-1:0] cap_r, cap_nxt;
  logic                       capv_r, capv_nxt;
  logic                       eil_r, eil_nxt;
  logic [tlnz_pkg::LCL_W-1:0] lines_r, lines_nxt;
  logic [tlnz_pkg::TBL_W-1:0] bytes_r, bytes_nxt;
  logic                       stop_r, stop_nxt;
  logic                       mal_r, mal_nxt;

  logic                       accept;
  logic                       is_cont;
  logic                       fit1, fit2;
  logic [tlnz_pkg::POS_W-1:0] lp_inc, lp_inc2;
  logic                       stop_now;
  logic [tlnz_pkg::TBL_W-1:0] rem;
  logic [tlnz_pkg::LBL_W-1:0] cap_new;
  logic [CNT_W-1:0]           emit_n;
  logic                       emit_space;
  tlnz_pkg::tlnz_tail_t       tail;

  assign in_ready  = push_ready;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Byte class and fit tests against the fixed cap of the current line.
  assign is_cont = (in_byte & tlnz_pkg::CONT_MASK) == tlnz_pkg::CONT_TAG;
  assign fit1    = (hc_r != '0) &&
                   (({1'b0, hs_r} + 18'(hc_r)) <= {2'b00, cap_r});
  assign fit2    = ({1'b0, lp_r} + 18'd1) <= {2'b00, cap_r};
  assign lp_inc  = (lp_r == tlnz_pkg::POS_MAX) ? lp_r : lp_r + 1'b1;
  assign lp_inc2 = (lp_inc == tlnz_pkg::POS_MAX) ? lp_inc : lp_inc + 1'b1;

  // Batch stop test and line cap, applied at the first item of a line.
  assign stop_now = stop_r || (lcl_r == '0) || (lbl_r == '0) || (tbl_r == '0) ||
                    (lines_r >= lcl_r) || (bytes_r >= tbl_r);
  assign rem      = tbl_r - bytes_r;
  assign cap_new  = stop_now ? '0 :
                    ((tlnz_pkg::TBL_W'(lbl_r) < rem) ? lbl_r : rem[tlnz_pkg::LBL_W-1:0]);

  // Next state and the request built from one item.
  always_comb begin
    grp_nxt    = grp_r;
    hc_nxt     = hc_r;
    hs_nxt     = hs_r;
    lp_nxt     = lp_r;
    sp_nxt     = sp_r;
    cap_nxt    = cap_r;
    capv_nxt   = capv_r;
    eil_nxt    = eil_r;
    lines_nxt  = lines_r;
    stop_nxt   = stop_r;
    mal_nxt    = mal_r;
    emit_n     = '0;
    emit_space = 1'b0;
    tail       = '0;
    case (in_op)
      tlnz_pkg::OP_BYTE: begin
        if (!capv_r) begin
          capv_nxt = 1'b1;
          stop_nxt = stop_now;
          cap_nxt  = cap_new;
        end
        if (in_byte == tlnz_pkg::DEL_CHAR) begin
          // Dropped byte.
        end else if (in_byte <= tlnz_pkg::SPACE_CHAR) begin
          sp_nxt = lp_r != '0;
        end else if (sp_r) begin
          // Pending space goes out alone, or is held with a continuation byte.
          emit_n = fit1 ? hc_r : '0;
          sp_nxt = 1'b0;
          if (is_cont) begin
            grp_nxt[0] = tlnz_pkg::SPACE_CHAR;
            grp_nxt[1] = in_byte;
            hc_nxt     = CNT_W'(2);
            hs_nxt     = lp_r;
            lp_nxt     = lp_inc2;
          end else begin
            emit_space = fit2;
            grp_nxt[0] = in_byte;
            hc_nxt     = CNT_W'(1);
            hs_nxt     = lp_inc;
            lp_nxt     = lp_inc2;
          end
          if (fit1 || (fit2 && !is_cont)) begin
            eil_nxt = 1'b1;
          end
          tail.valid = emit_space;
          tail.kind  = tlnz_pkg::KIND_DATA;
        end else if (is_cont && (hc_r != '0)) begin
          // Continuation byte joins the held character, if there is room.
          if (hc_r < CNT_W'(GROUP_MAX)) begin
            grp_nxt[hc_r[IDX_W-1:0]] = in_byte;
            hc_nxt = hc_r + 1'b1;
            lp_nxt = lp_inc;
          end else begin
            mal_nxt = 1'b1;
          end
        end else begin
          // New character: the held one goes out if it fits.
          emit_n     = fit1 ? hc_r : '0;
          eil_nxt    = eil_r || fit1;
          grp_nxt[0] = in_byte;
          hc_nxt     = CNT_W'(1);
          hs_nxt     = lp_r;
          lp_nxt     = lp_inc;
        end
      end
      tlnz_pkg::OP_EOL: begin
        if (!capv_r) begin
          stop_nxt = stop_now;
        end
        emit_n = fit1 ? hc_r : '0;
        if (eil_r || fit1) begin
          tail.valid     = 1'b1;
          tail.kind      = tlnz_pkg::KIND_EOL;
          tail.malformed = mal_r;
          lines_nxt      = lines_r + 1'b1;
        end
        hc_nxt   = '0;
        hs_nxt   = '0;
        lp_nxt   = '0;
        sp_nxt   = 1'b0;
        cap_nxt  = '0;
        capv_nxt = 1'b0;
        eil_nxt  = 1'b0;
        mal_nxt  = 1'b0;
      end
      tlnz_pkg::OP_BATCH: begin
        hc_nxt    = '0;
        hs_nxt    = '0;
        lp_nxt    = '0;
        sp_nxt    = 1'b0;
        cap_nxt   = '0;
        capv_nxt  = 1'b0;
        eil_nxt   = 1'b0;
        mal_nxt   = 1'b0;
        lines_nxt = '0;
        stop_nxt  = 1'b0;
      end
      default: begin
        // Unused code: no effect.
      end
    endcase
  end

  // Byte budget tracking.
  always_comb begin
    if (in_op == tlnz_pkg::OP_BATCH) begin
      bytes_nxt = '0;
    end else begin
      bytes_nxt = bytes_r + tlnz_pkg::TBL_W'(emit_n) + tlnz_pkg::TBL_W'(emit_space);
    end
  end

  // Request toward the queue; the bytes are the held character before update.
  assign push_valid = accept && ((emit_n != '0) || tail.valid);
  assign push_bytes = grp_r;
  assign push_n     = emit_n;
  assign push_tail  = tail;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcl_r <= tlnz_pkg::LCL_RESET;
      lbl_r <= tlnz_pkg::LBL_RESET;
      tbl_r <= tlnz_pkg::TBL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlnz_pkg::CFG_LINE_COUNT:  lcl_r <= cfg_data[tlnz_pkg::LCL_W-1:0];
        tlnz_pkg::CFG_LINE_BYTES:  lbl_r <= cfg_data[tlnz_pkg::LBL_W-1:0];
        tlnz_pkg::CFG_TOTAL_BYTES: tbl_r <= cfg_data[tlnz_pkg::TBL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Held character bytes carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      grp_r <= grp_nxt;
    end
  end

  // Line and batch state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r    <= '0;
      hs_r    <= '0;
      lp_r    <= '0;
      sp_r    <= 1'b0;
      cap_r   <= '0;
      capv_r  <= 1'b0;
      eil_r   <= 1'b0;
      lines_r <= '0;
      bytes_r <= '0;
      stop_r  <= 1'b0;
      mal_r   <= 1'b0;
    end else if (accept) begin
      hc_r    <= hc_nxt;
      hs_r    <= hs_nxt;
      lp_r    <= lp_nxt;
      sp_r    <= sp_nxt;
      cap_r   <= cap_nxt;
      capv_r  <= capv_nxt;
      eil_r   <= eil_nxt;
      lines_r <= lines_nxt;
      bytes_r <= bytes_nxt;
      stop_r  <= stop_nxt;
      mal_r   <= mal_nxt;
    end
  end

`include "assert_macros.svh"

  // A line whose cap is not yet fixed holds no character, so flushes never
  // need the cap that is computed in the same cycle.
  `TLNZ_ASSERT_IMPL(a_open_line_empty, clk, rst_n, !capv_r, hc_r == '0, "held bytes before line cap")
  `TLNZ_ASSERT_IMPL(a_stopped_cap_zero, clk, rst_n, capv_r && stop_r, cap_r == '0, "stopped batch with nonzero cap")
  `TLNZ_ASSERT(a_held_count_range, clk, rst_n, hc_r <= CNT_W'(GROUP_MAX), "held count beyond group buffer")

endmodule

`default_nettype wire

[rtl/tlnz_queue.sv]
// Small register queue of result requests between front and back end.
`default_nettype none

module tlnz_queue #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`include "assert_macros.svh"

  `TLNZ_ASSERT(a_count_range, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue count overflow")

endmodule

`default_nettype wire

[rtl/tlnz_back.sv]
// Back end: expands queued requests into single results in an output register.
`default_nettype none

module tlnz_back #(
  parameter int unsigned GROUP_MAX = 4,
  localparam int unsigned CNT_W = $clog2(GROUP_MAX + 1),
  localparam int unsigned IDX_W = $clog2(GROUP_MAX)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Head of the queue.
  input  wire logic                     q_valid,
  input  wire logic [GROUP_MAX-1:0][7:0] q_bytes,
  input  wire logic [CNT_W-1:0]         q_n,
  input  wire tlnz_pkg::tlnz_tail_t     q_tail,
  output logic                          q_pop,
  // Result channel.
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_kind,
  output logic                          out_malformed,
  output logic                          out_last
);

  logic [CNT_W-1:0] pos_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_kind_r, out_mal_r, out_last_r;

  logic             load;
  logic             is_byte;
  logic             sel_last;
  logic [7:0]       sel_byte;
  logic             sel_kind, sel_mal;

  // Result at the current position of the head entry.
  assign is_byte  = pos_r < q_n;
  assign sel_last = is_byte ? ((pos_r == (q_n - 1'b1)) && !q_tail.valid) : 1'b1;
  always_comb begin
    if (is_byte) begin
      sel_byte = q_bytes[pos_r[IDX_W-1:0]];
      sel_kind = tlnz_pkg::KIND_DATA;
      sel_mal  = 1'b0;
    end else if (q_tail.kind == tlnz_pkg::KIND_EOL) begin
      sel_byte = 8'h00;
      sel_kind = tlnz_pkg::KIND_EOL;
      sel_mal  = q_tail.malformed;
    end else begin
      sel_byte = tlnz_pkg::SPACE_CHAR;
      sel_kind = tlnz_pkg::KIND_DATA;
      sel_mal  = 1'b0;
    end
  end

  // The output register takes a new result when empty or being drained.
  assign load  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = load && sel_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_byte;
      out_kind_r <= sel_kind;
      out_mal_r  <= sel_mal;
      out_last_r <= sel_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= sel_last ? '0 : pos_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_kind      = out_kind_r;
  assign out_malformed = out_mal_r;
  assign out_last      = out_last_r;

`include "assert_macros.svh"

  // Part way through an entry, that entry must still sit at the queue head.
  `TLNZ_ASSERT_IMPL(a_mid_entry_head, clk, rst_n, pos_r != '0, q_valid, "entry left queue early")

endmodule

`default_nettype wire

[rtl/text_line_normalizer_top.sv]
// Top level of the text line normalizer.
//
// Text line normalizer: takes one input request per cycle (text byte, end of
// line or start of batch) while the request queue between the front end and
// the back end has room, and gives normalized bytes and end of line markers
// on a stream output, one result per cycle while out_tready is high and
// requests are queued. An accepted request with results goes into the queue and
// is then loaded into the back end output register. A request that causes k
// results (at most GROUP_MAX + 1) keeps the back end busy until all k are out;
// the QUEUE_DEPTH entry queue absorbs such bursts, so new requests are taken
// while earlier ones are still expanded, until it is full. Configuration
// writes are always taken and must be made while the block is idle.
`default_nettype none

module text_line_normalizer_top #(
  parameter int unsigned GROUP_MAX   = 4,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] byte_value
  input  wire logic [1:0]                          in_tuser,   // [1:0] op
  // Result stream.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [7:0]                               out_tdata,  // [7:0] out_byte
  output logic [1:0]                               out_tuser,  // [0] kind, [1] malformed
  output logic                                     out_tlast,
  // Configuration writes.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tlnz_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tlnz_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CNT_W  = $clog2(GROUP_MAX + 1);
  localparam int unsigned TAIL_W = $bits(tlnz_pkg::tlnz_tail_t);
  localparam int unsigned Q_W    = GROUP_MAX * 8 + CNT_W + TAIL_W;

  logic                      push_valid, push_ready;
  logic [GROUP_MAX-1:0][7:0] push_bytes;
  logic [CNT_W-1:0]          push_n;
  tlnz_pkg::tlnz_tail_t      push_tail;

  logic                      q_valid, q_pop;
  logic [Q_W-1:0]            q_data;
  logic [GROUP_MAX-1:0][7:0] q_bytes;
  logic [CNT_W-1:0]          q_n;
  tlnz_pkg::tlnz_tail_t      q_tail;

  logic                      out_kind, out_mal;

  // Front end: line state and request building.
  tlnz_front #(
    .GROUP_MAX(GROUP_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_bytes (push_bytes),
    .push_n     (push_n),
    .push_tail  (push_tail)
  );

  // Request queue.
  tlnz_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_tail, push_n, push_bytes}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign {q_tail, q_n, q_bytes} = q_data;

  // Back end: one result per cycle into the output register while it is empty or being drained.
  tlnz_back #(
    .GROUP_MAX(GROUP_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_bytes       (q_bytes),
    .q_n           (q_n),
    .q_tail        (q_tail),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_tdata),
    .out_kind      (out_kind),
    .out_malformed (out_mal),
    .out_last      (out_tlast)
  );

  assign out_tuser = {out_mal, out_kind};

endmodule

`default_nettype wire

[verif/text_line_normalizer_top_tb.sv]
// Self-checking testbench of the text line normalizer top level.
module text_line_normalizer_top_tb;

  localparam int unsigned GROUP_MAX        = 4;
  localparam int unsigned SETTLE_CYCLES    = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS      = 22;
  localparam int unsigned NUM_PHASES       = 6;

  // Codes that the block has to ignore.
  localparam logic [1:0]                     OP_UNUSED  = 2'd3;
  localparam logic [tlnz_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One normalized output item, as it leaves the block.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       malformed;
    logic       last;
  } norm_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;
  // How a directed row is checked: computed, no output at all, or one typed result.
  typedef enum logic [1:0] { CHK_CALC, CHK_NONE, CHK_ONE } row_check_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [1:0]   code;   // op for an item, register index for a write
    logic [19:0]  value;  // byte for an item, data for a write
    row_check_t   chk;
    norm_result_t res;
  } dir_row_t;

  localparam norm_result_t NO_RES = '0;
  localparam int unsigned DIR_ROWS = 37;

  // Directed walk: whitespace folding, DEL, UTF-8 groups, cuts, zero and maximum limits.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_ITEM, tlnz_pkg::OP_BATCH,        20'h00,    CHK_NONE, NO_RES},
    '{ROW_ITEM, OP_UNUSED,                 20'h5A,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h20,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h41,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h00,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h7F,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'hFF,    CHK_CALC, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h80,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h80,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'hBF,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h80,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_CALC, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h9F,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'hC3,    CHK_ONE,
      '{tlnz_pkg::KIND_DATA, 8'h9F, 1'b0, 1'b1}},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'hA9,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h09,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_CALC, NO_RES},
    '{ROW_CFG,  tlnz_pkg::CFG_LINE_BYTES,  20'h00002, CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h61,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'hC3,    CHK_ONE,
      '{tlnz_pkg::KIND_DATA, 8'h61, 1'b0, 1'b1}},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'hA9,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_ONE,
      '{tlnz_pkg::KIND_EOL, 8'h00, 1'b0, 1'b1}},
    '{ROW_CFG,  tlnz_pkg::CFG_TOTAL_BYTES, 20'h00000, CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h62,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_NONE, NO_RES},
    '{ROW_CFG,  tlnz_pkg::CFG_TOTAL_BYTES, 20'hFFFFF, CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h63,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BATCH,        20'h00,    CHK_NONE, NO_RES},
    '{ROW_CFG,  tlnz_pkg::CFG_LINE_COUNT,  20'h00001, CHK_NONE, NO_RES},
    '{ROW_CFG,  tlnz_pkg::CFG_LINE_BYTES,  20'h0FFFF, CHK_NONE, NO_RES},
    '{ROW_CFG,  CFG_UNUSED,                20'h5A5A5, CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h7E,    CHK_NONE, NO_RES},
    '{ROW_CFG,  tlnz_pkg::CFG_LINE_BYTES,  20'h00000, CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_CALC, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_BYTE,         20'h21,    CHK_NONE, NO_RES},
    '{ROW_ITEM, tlnz_pkg::OP_EOL,          20'h00,    CHK_NONE, NO_RES}
  };

  // Block ports.
  logic                            clk;
  logic                            rst_n       = 1'b0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata    = '0;
  logic [1:0]                      in_tuser    = '0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [7:0]                      out_tdata;
  logic [1:0]                      out_tuser;
  logic                            out_tlast;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [tlnz_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [tlnz_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  // Limits as last written.
  logic [15:0] reg_line_count;
  logic [15:0] reg_line_bytes;
  logic [19:0] reg_total_bytes;

  // Line and batch state of the normalizer.
  logic [7:0]  char_buf [GROUP_MAX];
  int unsigned char_len;
  logic [16:0] char_start;
  logic [16:0] line_len;
  bit          gap_owed;
  logic [15:0] cap_now;
  bit          cap_fixed;
  bit          line_shown;
  logic [15:0] batch_lines;
  logic [19:0] batch_bytes;
  bit          batch_halt;
  bit          run_overflow;

  // Output that one request causes, and all output still owed by the block.
  norm_result_t step_res [$];
  norm_result_t out_due  [$];
  norm_result_t want;
  norm_result_t got;

  // Run control and statistics.
  bit          quiet         = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned results_seen  = 0;
  int unsigned lines_seen    = 0;
  int unsigned flagged_lines = 0;

  text_line_normalizer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] byte_value
    .in_tuser   (in_tuser),   // [1:0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tuser  (out_tuser),  // [0] kind, [1] malformed
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A fixed upper bound on the run time.
  initial begin
    #4000000;
    $display("** text_line_normalizer_top: FAILED **");
    $finish;
  end

  function automatic void out_push(logic k, logic [7:0] d, logic m);
    norm_result_t r;
    r = '{k, d, m, 1'b0};
    step_res.insert(step_res.size(), r);
  endfunction

  // The first item of a line fixes its cap and decides whether the batch has stopped.
  function automatic void line_open();
    logic [19:0] rem;
    if (cap_fixed) return;
    cap_fixed = 1'b1;
    if (reg_line_count == 0 || reg_line_bytes == 0 || reg_total_bytes == 0 ||
        batch_lines >= reg_line_count || batch_bytes >= reg_total_bytes)
      batch_halt = 1'b1;
    if (batch_halt) begin
      cap_now = '0;
    end else begin
      rem = reg_total_bytes - batch_bytes;
      cap_now = (20'(reg_line_bytes) < rem) ? reg_line_bytes : rem[15:0];
    end
  endfunction

  // The held character goes out only if all of it fits under the cap.
  function automatic void char_flush();
    if (char_len != 0 && 32'(char_start) + char_len <= 32'(cap_now)) begin
      for (int i = 0; i < char_len; i++) out_push(tlnz_pkg::KIND_DATA, char_buf[i], 1'b0);
      batch_bytes = batch_bytes + 20'(char_len);
      line_shown = 1'b1;
    end
    char_len = 0;
  endfunction

  function automatic void line_step_pos();
    if (line_len != tlnz_pkg::POS_MAX) line_len++;
  endfunction

  // A start byte opens a new character; a continuation byte joins the held one.
  function automatic void char_take(logic [7:0] b);
    if ((b & tlnz_pkg::CONT_MASK) != tlnz_pkg::CONT_TAG || char_len == 0) begin
      char_flush();
      char_buf[0] = b;
      char_len = 1;
      char_start = line_len;
      line_step_pos();
    end else if (char_len < GROUP_MAX) begin
      char_buf[char_len] = b;
      char_len++;
      line_step_pos();
    end else begin
      run_overflow = 1'b1;
    end
  endfunction

  function automatic void line_forget();
    char_len = 0;
    char_start = '0;
    line_len = '0;
    gap_owed = 1'b0;
    cap_now = '0;
    cap_fixed = 1'b0;
    line_shown = 1'b0;
    run_overflow = 1'b0;
  endfunction

  // Work out the output that one input request causes.
  function automatic void normalize_step(logic [1:0] op, logic [7:0] b);
    step_res.delete();
    case (op)
      tlnz_pkg::OP_BYTE: begin
        line_open();
        // DEL is dropped without a trace.
        if (b != tlnz_pkg::DEL_CHAR) begin
          if (b <= tlnz_pkg::SPACE_CHAR) begin
            gap_owed = (line_len != 0);
          end else begin
            if (gap_owed) begin
              char_take(tlnz_pkg::SPACE_CHAR);
              gap_owed = 1'b0;
            end
            char_take(b);
          end
        end
      end
      tlnz_pkg::OP_EOL: begin
        line_open();
        char_flush();
        if (line_shown) begin
          out_push(tlnz_pkg::KIND_EOL, 8'h00, run_overflow);
          batch_lines++;
        end
        line_forget();
      end
      tlnz_pkg::OP_BATCH: begin
        line_forget();
        batch_lines = '0;
        batch_bytes = '0;
        batch_halt = 1'b0;
      end
      default: begin
      end
    endcase
    if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic void field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
    end
  endfunction

  // Stop offering requests and wait until the block has nothing more to give.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (out_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tlnz_pkg::CFG_IDX_W-1:0] idx,
                           input logic [19:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tlnz_pkg::CFG_LINE_COUNT:  reg_line_count = val[15:0];
      tlnz_pkg::CFG_LINE_BYTES:  reg_line_bytes = val[15:0];
      tlnz_pkg::CFG_TOTAL_BYTES: reg_total_bytes = val;
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // Offer one request; valid stays high on return so the next request can follow at once.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input row_check_t chk, input norm_result_t pin);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    normalize_step(op, b);
    case (chk)
      CHK_CALC: foreach (step_res[i]) out_due.insert(out_due.size(), step_res[i]);
      CHK_ONE:  out_due.insert(out_due.size(), pin);
      default: begin
      end
    endcase
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (out_due.size() == 0) begin
        fail_count++;
        $error("unexpected result: kind %0b byte %0h malformed %0b last %0b",
               out_tuser[0], out_tdata, out_tuser[1], out_tlast);
      end else begin
        want = out_due.pop_front();
        got  = '{out_tuser[0], out_tdata, out_tuser[1], out_tlast};
        field_check("kind", 8'(want.kind), 8'(got.kind));
        field_check("out_byte", want.data, got.data);
        field_check("malformed", 8'(want.malformed), 8'(got.malformed));
        field_check("last", 8'(want.last), 8'(got.last));
        results_seen++;
        if (want.kind == tlnz_pkg::KIND_EOL) lines_seen++;
        if (want.malformed) flagged_lines++;
      end
    end
  end

  initial begin
    logic [15:0] lim_count;
    logic [15:0] lim_line;
    logic [19:0] lim_total;
    logic [7:0]  lead;
    int unsigned n_tok;
    int unsigned seq_len;
    int unsigned phase_base;
    bit          mid_paused;

    reg_line_count = tlnz_pkg::LCL_RESET;
    reg_line_bytes = tlnz_pkg::LBL_RESET;
    reg_total_bytes = tlnz_pkg::TBL_RESET;
    line_forget();
    batch_lines = '0;
    batch_bytes = '0;
    batch_halt = 1'b0;
    mid_paused = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_CFG)
        cfg_write(DIR_TABLE[r].code, DIR_TABLE[r].value);
      else
        send_item(DIR_TABLE[r].code, DIR_TABLE[r].value[7:0], DIR_TABLE[r].chk,
                  DIR_TABLE[r].res);
    end

    // Random part, one limit setting per phase.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          lim_count = tlnz_pkg::LCL_RESET;
          lim_line  = tlnz_pkg::LBL_RESET;
          lim_total = tlnz_pkg::TBL_RESET;
        end
        1: begin
          lim_count = 16'd3;
          lim_line  = 16'($urandom_range(1, 10));
          lim_total = 20'($urandom_range(20, 60));
        end
        2: begin
          lim_count = 16'hFFFF;
          lim_line  = 16'hFFFF;
          lim_total = 20'hFFFFF;
        end
        3: begin
          lim_count = 16'($urandom_range(1, 4));
          lim_line  = 16'($urandom_range(1, 3));
          lim_total = 20'($urandom_range(1, 8));
        end
        4: begin
          lim_count = 16'($urandom_range(1, 8));
          lim_line  = 16'($urandom_range(1, 12));
          lim_total = 20'($urandom_range(1, 40));
          // One zero limit shuts the output off.
          case ($urandom_range(0, 2))
            0: lim_count = '0;
            1: lim_line = '0;
            default: lim_total = '0;
          endcase
        end
        default: begin
          lim_count = 16'($urandom_range(1, 6));
          lim_line  = 16'($urandom_range(2, 16));
          lim_total = 20'($urandom_range(16, 200));
        end
      endcase
      cfg_write(tlnz_pkg::CFG_LINE_COUNT, 20'(lim_count));
      cfg_write(tlnz_pkg::CFG_LINE_BYTES, 20'(lim_line));
      cfg_write(tlnz_pkg::CFG_TOTAL_BYTES, lim_total);
      quiet = (ph == NUM_PHASES - 1) || ($urandom_range(0, 2) == 0);
      // Hold the result side off while requests keep coming, so the queue fills.
      if (ph == 0) hold_requests++;
      phase_base = items_sent;

      while (items_sent - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0)
          send_item(tlnz_pkg::OP_BATCH, 8'($urandom), CHK_CALC, NO_RES);
        if ($urandom_range(0, 9) == 0) send_item(OP_UNUSED, 8'($urandom), CHK_CALC, NO_RES);
        n_tok = $urandom_range(0, 5);
        for (int t = 0; t < n_tok; t++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              // Printable word.
              repeat ($urandom_range(1, 5))
                send_item(tlnz_pkg::OP_BYTE, 8'($urandom_range(8'h21, 8'h7E)),
                          CHK_CALC, NO_RES);
            end
            4, 5: begin
              // Well-formed UTF-8 character of two to four bytes.
              seq_len = $urandom_range(2, 4);
              if (seq_len == 2)      lead = 8'hC0 | 8'($urandom_range(0, 31));
              else if (seq_len == 3) lead = 8'hE0 | 8'($urandom_range(0, 15));
              else                   lead = 8'hF0 | 8'($urandom_range(0, 7));
              send_item(tlnz_pkg::OP_BYTE, lead, CHK_CALC, NO_RES);
              repeat (seq_len - 1)
                send_item(tlnz_pkg::OP_BYTE, tlnz_pkg::CONT_TAG | 8'($urandom_range(0, 63)),
                          CHK_CALC, NO_RES);
            end
            6: begin
              // Whitespace and control bytes.
              repeat ($urandom_range(1, 3))
                send_item(tlnz_pkg::OP_BYTE, 8'($urandom_range(0, 32)), CHK_CALC, NO_RES);
            end
            7: send_item(tlnz_pkg::OP_BYTE, tlnz_pkg::DEL_CHAR, CHK_CALC, NO_RES);
            8: begin
              // Continuation run that can overflow the character buffer.
              repeat ($urandom_range(4, 6))
                send_item(tlnz_pkg::OP_BYTE, tlnz_pkg::CONT_TAG | 8'($urandom_range(0, 63)),
                          CHK_CALC, NO_RES);
            end
            default: send_item(tlnz_pkg::OP_BYTE, 8'($urandom), CHK_CALC, NO_RES);
          endcase
        end
        // Most lines end cleanly; a few are cut short by a new batch.
        if ($urandom_range(0, 9) == 0)
          send_item(tlnz_pkg::OP_BATCH, 8'($urandom), CHK_CALC, NO_RES);
        else
          send_item(tlnz_pkg::OP_EOL, 8'($urandom), CHK_CALC, NO_RES);
        // Once, the sender waits in mid-phase until all owed output has arrived.
        if (ph == 2 && !mid_paused && items_sent - phase_base >= PHASE_ITEMS / 2) begin
          settle();
          mid_paused = 1'b1;
        end
      end
    end

    settle();
    $display("Run covered %0d input requests and %0d register writes over several limits.",
             items_sent, cfg_writes);
    $display("Checked %0d results: %0d emitted lines, %0d of them flagged malformed.",
             results_seen, lines_seen, flagged_lines);
    if (fail_count == 0 && out_due.size() == 0) begin
      $display("** text_line_normalizer_top: PASSED **");
    end else begin
      $display("** text_line_normalizer_top: FAILED **");
    end
    $finish;
  end

endmodule
